// ===== hw/rtl/mncp_pkg.sv =====
// Shared types, constants and helpers for the matrix norm closest-pair block.
// No dependencies; every other file of the block but mncp_ram imports this package.
package mncp_pkg;

   // Input row: three signed Q8.8 elements.
   localparam int ELEM_W     = 16;
   localparam int LANES      = 3;
   localparam int ROWS       = 3;
   localparam int ROW_W      = 2;

   // Digit-serial squaring: one 4-bit digit of the multiplier per cycle.
   localparam int DIGIT_W    = 4;
   localparam int DIGITS     = ELEM_W / DIGIT_W;
   localparam int DIG_CNT_W  = $clog2(DIGITS);
   localparam int PROD_W     = 2 * ELEM_W;

   // Sum of squares and its square root, one root bit per cycle.
   localparam int SUM_W      = 35;
   localparam int ROOT_STEPS = (SUM_W + 1) / 2;
   localparam int RAD_W      = 2 * ROOT_STEPS;
   localparam int ROOT_W     = ROOT_STEPS;
   localparam int REM_W      = ROOT_STEPS + 1;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam int NORM_W     = 17;
   localparam int NORM_MAX   = 98304;

   // Norm store.
   localparam int MAX_MATRICES = 64;
   localparam int ADDR_W       = $clog2(MAX_MATRICES);
   localparam int COUNT_W      = $clog2(MAX_MATRICES + 1);

   // Result fields.
   localparam int IDX_W      = 7;
   localparam int DIST_W     = 17;
   localparam int STATUS_W   = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FEW   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_CHECK,
      ST_RD_A,
      ST_GET_A,
      ST_CMP,
      ST_DONE
   } state_type;

   // Magnitude of a two's complement element; the most negative value maps
   // to its true magnitude, which still fits the unsigned width.
   function automatic logic [ELEM_W-1:0] magnitude(input logic [ELEM_W-1:0] v);
      logic [ELEM_W-1:0] r;
      if (v[ELEM_W-1]) begin
         r = ~v + 1'b1;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Low bits of a 1-based matrix number, as carried by the index fields.
   function automatic logic [IDX_W-1:0] to_field_index(input logic [COUNT_W-1:0] v);
      logic [COUNT_W+IDX_W-1:0] w;
      w = {{IDX_W{1'b0}}, v};
      return w[IDX_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/mncp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mncp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mncp_isqrt.sv =====
// Restoring integer square root, one root bit per cycle.
// Depends on mncp_pkg for the radicand, remainder and root widths.
module mncp_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mncp_pkg::SUM_W-1:0]  radicand,
   output logic                        done,
   output logic [mncp_pkg::NORM_W-1:0] root
);
   import mncp_pkg::*;

   logic [RAD_W-1:0]  rad_ff,  rad_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W+1:0]  shifted;
   logic [REM_W+1:0]  trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = (REM_W + 2)'({root_ff, 2'b01});
      if (start) begin
         rad_in  = (RAD_W)'(radicand);
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Bring down the next pair of radicand bits and try the next root bit.
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = REM_W'(shifted - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(shifted);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign root = root_ff[NORM_W-1:0];

endmodule

// ===== hw/rtl/matrix_norm_closest_pair_top.sv =====
// Top level of the matrix norm closest-pair block: row squaring, norm store
// and pair search. Depends on mncp_pkg, mncp_ram and mncp_isqrt.
//
//   Channel | Direction | Ports                                   | Moves
//   --------+-----------+-----------------------------------------+--------------------------
//   req     | in        | req_valid/ready, elem_a/b/c, last_row   | one matrix row per item
//   rsp     | out       | rsp_valid/ready, indices, distance, st. | one result per last row
//
// A row item passes through accept, the digit-serial squaring lanes, the row sum
// and a check. The row that completes a matrix, when the store has room, also
// waits for the square root unit, which produces one root bit per cycle. A last
// row adds the pair search over every pair in the norm store, which has one
// read port.
// Reset is synchronous and active high; it clears the control state and empties
// the set. The norm store is not cleared: only entries already written are read.
// A result waiting on rsp does not hold back further rows; only the next result
// waits for it to be taken.
module matrix_norm_closest_pair_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [mncp_pkg::ELEM_W-1:0] req_elem_a,
   input  logic signed [mncp_pkg::ELEM_W-1:0] req_elem_b,
   input  logic signed [mncp_pkg::ELEM_W-1:0] req_elem_c,
   input  logic                          req_last_row,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mncp_pkg::IDX_W-1:0]    rsp_first_index,
   output logic [mncp_pkg::IDX_W-1:0]    rsp_second_index,
   output logic [mncp_pkg::DIST_W-1:0]   rsp_distance,
   output logic [mncp_pkg::STATUS_W-1:0] rsp_status
);
   import mncp_pkg::*;

   // Control state.
   state_type            state_ff, state_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 overflow_ff, overflow_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Squaring lanes: the multiplicand shifts left and the multiplier right by
   // one digit a cycle.
   logic [PROD_W-1:0]    mcand_ff [LANES];
   logic [PROD_W-1:0]    mcand_in [LANES];
   logic [ELEM_W-1:0]    mult_ff  [LANES];
   logic [ELEM_W-1:0]    mult_in  [LANES];
   logic [PROD_W-1:0]    prod_ff  [LANES];
   logic [PROD_W-1:0]    prod_in  [LANES];
   logic [PROD_W-1:0]    partial  [LANES];
   logic [ELEM_W-1:0]    elem     [LANES];
   logic [DIG_CNT_W-1:0] dig_ff, dig_in;
   logic                 last_ff, last_in;
   logic [SUM_W-1:0]     sum_next;

   // Pair search.
   logic [ADDR_W-1:0]    i_ff, i_in;
   logic [ADDR_W-1:0]    j_ff, j_in;
   logic [NORM_W-1:0]    a_ff, a_in;
   logic                 have_ff, have_in;
   logic [ADDR_W-1:0]    best_i_ff, best_i_in;
   logic [ADDR_W-1:0]    best_j_ff, best_j_in;
   logic [NORM_W-1:0]    best_d_ff, best_d_in;
   logic [NORM_W-1:0]    diff;

   // Result register.
   logic [IDX_W-1:0]     rsp_first_ff, rsp_first_in;
   logic [IDX_W-1:0]     rsp_second_ff, rsp_second_in;
   logic [DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // Square root unit and norm store.
   logic                 root_start;
   logic                 root_done;
   logic [NORM_W-1:0]    root;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [NORM_W-1:0]    ram_rd_data;

   assign elem[0] = unsigned'(req_elem_a);
   assign elem[1] = unsigned'(req_elem_b);
   assign elem[2] = unsigned'(req_elem_c);

   assign sum_next = sum_ff + SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1])
                   + SUM_W'(prod_ff[2]);

   assign diff = (a_ff >= ram_rd_data) ? (a_ff - ram_rd_data) : (ram_rd_data - a_ff);

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         partial[l] = mcand_ff[l] * mult_ff[l][DIGIT_W-1:0];
      end
   end

   mncp_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_next),
      .done     (root_done),
      .root     (root)
   );

   mncp_ram #(
      .WIDTH (NORM_W),
      .DEPTH (MAX_MATRICES)
   ) u_norm_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (root),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff;
      dig_in        = dig_ff;
      last_in       = last_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      a_in          = a_ff;
      have_in       = have_ff;
      best_i_in     = best_i_ff;
      best_j_in     = best_j_ff;
      best_d_in     = best_d_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_status_in = rsp_status_ff;
      for (int l = 0; l < LANES; l++) begin
         mcand_in[l] = mcand_ff[l];
         mult_in[l]  = mult_ff[l];
         prod_in[l]  = prod_ff[l];
      end
      root_start  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_addr = i_ff;
      req_ready   = 1'b0;

      // The taken result frees the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               for (int l = 0; l < LANES; l++) begin
                  mcand_in[l] = PROD_W'(magnitude(elem[l]));
                  mult_in[l]  = magnitude(elem[l]);
                  prod_in[l]  = '0;
               end
               dig_in   = '0;
               last_in  = req_last_row;
               state_in = ST_SQUARE;
            end
         end

         ST_SQUARE: begin
            for (int l = 0; l < LANES; l++) begin
               prod_in[l]  = prod_ff[l] + partial[l];
               mcand_in[l] = mcand_ff[l] << DIGIT_W;
               mult_in[l]  = mult_ff[l] >> DIGIT_W;
            end
            dig_in = dig_ff + 1'b1;
            if (dig_ff == DIG_CNT_W'(DIGITS - 1)) begin
               state_in = ST_SUM;
            end
         end

         ST_SUM: begin
            if (row_ff == ROW_W'(ROWS - 1)) begin
               // Matrix complete: take its norm if there is room for it.
               row_in = '0;
               sum_in = '0;
               if (count_ff < COUNT_W'(MAX_MATRICES)) begin
                  root_start = 1'b1;
                  state_in   = ST_ROOT;
               end else begin
                  overflow_in = 1'b1;
                  state_in    = ST_CHECK;
               end
            end else begin
               row_in   = row_ff + 1'b1;
               sum_in   = sum_next;
               state_in = ST_CHECK;
            end
         end

         ST_ROOT: begin
            if (root_done) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
               state_in  = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else begin
               have_in = 1'b0;
               i_in    = '0;
               if (count_ff < COUNT_W'(2)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RD_A;
               end
            end
         end

         ST_RD_A: begin
            ram_rd_addr = i_ff;
            state_in    = ST_GET_A;
         end

         ST_GET_A: begin
            a_in        = ram_rd_data;
            ram_rd_addr = i_ff + 1'b1;
            j_in        = i_ff + 1'b1;
            state_in    = ST_CMP;
         end

         ST_CMP: begin
            // Only a strictly smaller distance replaces the best pair.
            if (!have_ff || (diff < best_d_ff)) begin
               have_in   = 1'b1;
               best_d_in = diff;
               best_i_in = i_ff;
               best_j_in = j_ff;
            end
            if ((COUNT_W'(j_ff) + COUNT_W'(1)) < count_ff) begin
               ram_rd_addr = j_ff + 1'b1;
               j_in        = j_ff + 1'b1;
            end else if ((COUNT_W'(i_ff) + COUNT_W'(2)) < count_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_RD_A;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (count_ff < COUNT_W'(2)) begin
                  rsp_first_in  = '0;
                  rsp_second_in = '0;
                  rsp_dist_in   = '0;
                  rsp_status_in = STATUS_FEW;
               end else begin
                  rsp_first_in  = to_field_index(COUNT_W'(best_i_ff) + COUNT_W'(1));
                  rsp_second_in = to_field_index(COUNT_W'(best_j_ff) + COUNT_W'(1));
                  rsp_dist_in   = DIST_W'(best_d_ff);
                  rsp_status_in = overflow_ff ? STATUS_OVER : STATUS_OK;
               end
               // The set is closed; the next row opens a new one.
               row_in      = '0;
               sum_in      = '0;
               count_in    = '0;
               overflow_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      for (int l = 0; l < LANES; l++) begin
         mcand_ff[l] <= mcand_in[l];
         mult_ff[l]  <= mult_in[l];
         prod_ff[l]  <= prod_in[l];
      end
      dig_ff        <= dig_in;
      last_ff       <= last_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      a_ff          <= a_in;
      have_ff       <= have_in;
      best_i_ff     <= best_i_in;
      best_j_ff     <= best_j_in;
      best_d_ff     <= best_d_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_index  = rsp_first_ff;
   assign rsp_second_index = rsp_second_ff;
   assign rsp_distance     = rsp_dist_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== hw/rtl/mncp_checker.sv =====
// Port-level checks for the matrix norm closest-pair block, bound to its top level.
// Depends on mncp_pkg and matrix_norm_closest_pair_top.
module mncp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mncp_pkg::IDX_W-1:0]    rsp_first_index,
   input logic [mncp_pkg::IDX_W-1:0]    rsp_second_index,
   input logic [mncp_pkg::DIST_W-1:0]   rsp_distance,
   input logic [mncp_pkg::STATUS_W-1:0] rsp_status
);
   import mncp_pkg::*;

   // A waiting result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_index)
         && $stable(rsp_second_index) && $stable(rsp_distance) && $stable(rsp_status))
      else $error("result changed before it was taken");

   // No result is left over from before a reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // A set of fewer than two matrices reports an empty pair.
   a_few_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FEW |->
         rsp_first_index == '0 && rsp_second_index == '0 && rsp_distance == '0)
      else $error("empty set reported a pair");

   // A found pair is ordered and its distance lies within the norm range.
   a_pair_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK || rsp_status == STATUS_OVER)
         && (MAX_MATRICES < 128) |->
         rsp_first_index != '0 && rsp_first_index < rsp_second_index
         && rsp_distance <= DIST_W'(NORM_MAX))
      else $error("pair indices out of order or distance out of range");

   // Only defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_FEW
         || rsp_status == STATUS_OVER)
      else $error("undefined status code");

endmodule

bind matrix_norm_closest_pair_top mncp_checker u_mncp_checker (.*);

// ===== tb/sv/tb_matrix_norm_closest_pair_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for matrix_norm_closest_pair_top: drives matrix rows,
// predicts every closest-pair result and compares it. Depends on mncp_pkg and the RTL.
module tb_matrix_norm_closest_pair_top;
   import mncp_pkg::*;

   // Run length and timing bounds. The settling time after the last result exceeds
   // the pair search of a large set.
   localparam int RANDOM_ROWS   = 1930;
   localparam int HOLD_CYCLES   = 800;
   localparam int SETTLE_CYCLES = 2500;
   localparam int CYCLE_LIMIT   = 1000000;

   // Traffic phases: each item carries the phase it was generated in, and the
   // driver publishes the phase of the item it is offering so that the receiver
   // follows the same pattern.
   typedef enum int {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE
   } traffic_phase_t;

   typedef struct {
      logic signed [ELEM_W-1:0] elem_a;
      logic signed [ELEM_W-1:0] elem_b;
      logic signed [ELEM_W-1:0] elem_c;
      logic                     last_row;
      traffic_phase_t           phase;
   } row_item_t;

   typedef struct packed {
      logic [IDX_W-1:0]    first_index;
      logic [IDX_W-1:0]    second_index;
      logic [DIST_W-1:0]   distance;
      logic [STATUS_W-1:0] status;
   } closest_pair_t;

   // Every input has a known value from time zero.
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [ELEM_W-1:0] req_elem_a = '0;
   logic signed [ELEM_W-1:0] req_elem_b = '0;
   logic signed [ELEM_W-1:0] req_elem_c = '0;
   logic                     req_last_row = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [IDX_W-1:0]         rsp_first_index;
   logic [IDX_W-1:0]         rsp_second_index;
   logic [DIST_W-1:0]        rsp_distance;
   logic [STATUS_W-1:0]      rsp_status;

   row_item_t     rows_pending[$];
   closest_pair_t closest_expected[$];

   traffic_phase_t cur_phase = PH_STEADY;
   int unsigned    rows_offered = 0;
   int unsigned    rows_accepted = 0;
   int unsigned    hold_left = 0;
   bit             hold_done = 1'b0;
   int unsigned    hold_at = 0;
   int unsigned    cycle_count = 0;

   // Bookkeeping for the summary.
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned few_results = 0;
   int unsigned over_results = 0;
   int unsigned largest_set = 0;
   int unsigned held_stalls = 0;

   // Predictor state: the partly summed matrix, the stored norms of the current
   // set and whether any matrix of this set fell beyond the store.
   int unsigned      rows_open = 0;
   logic [SUM_W-1:0] running_sum = '0;
   logic [NORM_W-1:0] norm_table [MAX_MATRICES];
   int unsigned      stored_norms = 0;
   bit               dropped_matrix = 1'b0;

   matrix_norm_closest_pair_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_elem_a       (req_elem_a),
      .req_elem_b       (req_elem_b),
      .req_elem_c       (req_elem_c),
      .req_last_row     (req_last_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_first_index  (rsp_first_index),
      .rsp_second_index (rsp_second_index),
      .rsp_distance     (rsp_distance),
      .rsp_status       (rsp_status)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Exact square of a signed Q8.8 element; the most negative value squares
   // to 2^30, and the arithmetic is done in 64 bits.
   function automatic longint unsigned square_of(input logic signed [ELEM_W-1:0] e);
      longint signed v;
      v = longint'(e);
      if (v < 0) begin
         v = -v;
      end
      return v * v;
   endfunction

   // Floor square root, found one bit at a time from the top. The largest sum
   // three rows can give is 9 * 2^30, whose root 98304 fits the norm width.
   function automatic logic [NORM_W-1:0] floor_root(input logic [SUM_W-1:0] n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n) begin
            root = trial;
         end
      end
      return NORM_W'(root);
   endfunction

   // Folds one accepted row into the predictor. The third row of a matrix
   // stores its norm, or marks the set as over capacity when the store is full.
   // A last row searches every stored pair and queues the expected result.
   function automatic void apply_row(input logic signed [ELEM_W-1:0] a,
                                     input logic signed [ELEM_W-1:0] b,
                                     input logic signed [ELEM_W-1:0] c,
                                     input logic last);
      closest_pair_t res;
      int unsigned   gap;
      int unsigned   best_gap;
      int            best_i;
      int            best_j;
      bit            found;
      running_sum = SUM_W'(running_sum + square_of(a) + square_of(b) + square_of(c));
      rows_open++;
      if (rows_open >= ROWS) begin
         if (stored_norms < MAX_MATRICES) begin
            norm_table[stored_norms] = floor_root(running_sum);
            stored_norms++;
         end else begin
            dropped_matrix = 1'b1;
         end
         rows_open = 0;
         running_sum = '0;
      end
      if (!last) begin
         return;
      end
      res = '0;
      if (stored_norms < 2) begin
         res.status = STATUS_FEW;
      end else begin
         found = 1'b0;
         best_gap = 0;
         best_i = 0;
         best_j = 0;
         // Only a strictly smaller gap replaces the best pair, so ties keep
         // the earliest pair in scan order.
         for (int i = 0; i < stored_norms; i++) begin
            for (int j = i + 1; j < stored_norms; j++) begin
               gap = 32'((norm_table[i] > norm_table[j]) ? norm_table[i] - norm_table[j]
                                                         : norm_table[j] - norm_table[i]);
               if (!found || gap < best_gap) begin
                  found = 1'b1;
                  best_gap = gap;
                  best_i = i + 1;
                  best_j = j + 1;
               end
            end
         end
         res.first_index = IDX_W'(best_i);
         res.second_index = IDX_W'(best_j);
         res.distance = DIST_W'(best_gap);
         res.status = dropped_matrix ? STATUS_OVER : STATUS_OK;
      end
      closest_expected.push_back(res);
      // A search closes the set: any open partial matrix is discarded.
      rows_open = 0;
      running_sum = '0;
      stored_norms = 0;
      dropped_matrix = 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------

   function automatic void push_row(input logic signed [ELEM_W-1:0] a,
                                    input logic signed [ELEM_W-1:0] b,
                                    input logic signed [ELEM_W-1:0] c,
                                    input logic last, input traffic_phase_t ph);
      row_item_t item;
      item.elem_a = a;
      item.elem_b = b;
      item.elem_c = c;
      item.last_row = last;
      item.phase = ph;
      rows_pending.push_back(item);
   endfunction

   // Elements lean towards the extremes and small values, where squares and
   // norms are most likely to go wrong, but any 16-bit pattern can appear.
   function automatic logic signed [ELEM_W-1:0] fresh_element();
      logic signed [ELEM_W-1:0] e;
      case ($urandom_range(9))
         0: begin
            e = 16'sh8000;
         end
         1: begin
            e = 16'sh7FFF;
         end
         2: begin
            e = '0;
         end
         3: begin
            e = ELEM_W'(int'($urandom_range(511)) - 256);
         end
         default: begin
            e = ELEM_W'($urandom);
         end
      endcase
      return e;
   endfunction

   // Queues one set: a number of whole matrices, then optionally a partial
   // matrix that the block must drop. The final row carries last_row. Some
   // matrices repeat the previous one with random sign flips (equal norm, so a
   // tie) or with one element nudged by one (a very small distance).
   function automatic int queue_set(input int matrices, input int partial,
                                    input traffic_phase_t ph);
      logic signed [ELEM_W-1:0] cur [9];
      logic signed [ELEM_W-1:0] prev [9];
      int pick;
      int spot;
      if (matrices == 0 && partial == 0) begin
         partial = 1;
      end
      for (int m = 0; m < matrices; m++) begin
         pick = $urandom_range(9);
         for (int k = 0; k < 9; k++) begin
            if (m == 0 || pick < 6) begin
               cur[k] = fresh_element();
            end else if (pick < 9) begin
               cur[k] = ($urandom_range(1) == 1) ? -prev[k] : prev[k];
            end else begin
               cur[k] = prev[k];
            end
         end
         if (m > 0 && pick == 9) begin
            spot = $urandom_range(8);
            cur[spot] = cur[spot] + (($urandom_range(1) == 1) ? 16'sd1 : -16'sd1);
         end
         prev = cur;
         for (int r = 0; r < ROWS; r++) begin
            push_row(cur[3 * r], cur[3 * r + 1], cur[3 * r + 2],
                     m == matrices - 1 && partial == 0 && r == ROWS - 1, ph);
         end
      end
      for (int p = 0; p < partial; p++) begin
         push_row(fresh_element(), fresh_element(), fresh_element(), p == partial - 1, ph);
      end
      if (matrices > largest_set) begin
         largest_set = matrices;
      end
      return matrices * ROWS + partial;
   endfunction

   function automatic bit sender_idles(input traffic_phase_t ph);
      return (ph == PH_SENDER_IDLE && $urandom_range(99) < 80) ||
             (ph == PH_BOTH_IDLE && $urandom_range(99) < 21);
   endfunction

   function automatic bit receiver_stalls(input traffic_phase_t ph);
      return (ph == PH_RECEIVER_STALL && $urandom_range(99) < 80) ||
             (ph == PH_BOTH_IDLE && $urandom_range(99) < 21);
   endfunction

   function automatic void report_mismatch(input string what, input closest_pair_t got,
                                           input closest_pair_t want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s) at cycle %0d: got first %0d second %0d distance %0d status %0d,",
                  what, cycle_count, got.first_index, got.second_index, got.distance,
                  got.status);
         $display("   expected first %0d second %0d distance %0d status %0d",
                  want.first_index, want.second_index, want.distance, want.status);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: a new item is taken from the queue only once the previous one
   // has been accepted, which the two counters tell at the falling edge.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_rows
      row_item_t next_row;
      if (!reset && rows_offered == rows_accepted) begin
         if (rows_pending.size() > 0 && !sender_idles(rows_pending[0].phase)) begin
            next_row = rows_pending.pop_front();
            req_valid <= 1'b1;
            req_elem_a <= next_row.elem_a;
            req_elem_b <= next_row.elem_b;
            req_elem_c <= next_row.elem_c;
            req_last_row <= next_row.last_row;
            cur_phase <= next_row.phase;
            rows_offered <= rows_offered + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls at random by phase, and holds off entirely while the
   // hold-off counter runs.
   always @(negedge clock) begin
      if (reset || hold_left > 0) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !receiver_stalls(cur_phase);
      end
   end

   // Long receiver hold-off, started once the directed items are through. The
   // burst of small sets queued behind them keeps producing results, so the
   // block has to stop accepting rows until the receiver resumes.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && hold_at != 0 && rows_accepted >= hold_at) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks results against the oldest expectation, then feeds any
   // accepted row to the predictor. A result can never stem from a row
   // accepted at the same edge, so checking first is safe.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      closest_pair_t got;
      closest_pair_t want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_first_index, rsp_second_index, rsp_distance, rsp_status};
            results_seen++;
            if (closest_expected.size() == 0) begin
               report_mismatch("no result expected", got, '0);
            end else begin
               want = closest_expected.pop_front();
               if (want.status == STATUS_FEW) begin
                  few_results++;
               end else if (want.status == STATUS_OVER) begin
                  over_results++;
               end
               if (got.first_index !== want.first_index ||
                   got.second_index !== want.second_index ||
                   got.distance !== want.distance ||
                   got.status !== want.status) begin
                  report_mismatch("wrong field", got, want);
               end
            end
         end
         if (req_valid && req_ready) begin
            rows_accepted <= rows_accepted + 1;
            apply_row(req_elem_a, req_elem_b, req_elem_c, req_last_row);
         end
         if (hold_left > 0 && req_valid && !req_ready) begin
            held_stalls++;
         end
      end
   end

   // Watchdog against a hung block or a lost result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : run_test
      int unsigned queued;
      int unsigned set_no;
      int          matrices;
      int          partial;
      int          pick;
      traffic_phase_t ph;

      // Directed part. A lone last row: no matrix at all, too few to pair.
      push_row(16'sd0, 16'sd0, 16'sd0, 1'b1, PH_STEADY);
      // A single matrix of the most negative element: the largest norm, but
      // still too few matrices.
      for (int r = 0; r < ROWS; r++) begin
         push_row(16'sh8000, 16'sh8000, 16'sh8000, r == ROWS - 1, PH_STEADY);
      end
      // The largest norm against a zero matrix: the widest possible distance.
      for (int r = 0; r < ROWS; r++) begin
         push_row(16'sh8000, 16'sh8000, 16'sh8000, 1'b0, PH_STEADY);
      end
      for (int r = 0; r < ROWS; r++) begin
         push_row(16'sd0, 16'sd0, 16'sd0, 1'b0, PH_STEADY);
      end
      push_row(16'sd0, 16'sd0, 16'sd0, 1'b1, PH_STEADY);
      // Wait: the row above would open a new matrix, so close the set by
      // having that zero matrix end on the last row instead.
      rows_pending.delete(rows_pending.size() - 1);
      rows_pending[rows_pending.size() - 1].last_row = 1'b1;
      // Three matrices of equal norm (sign flips only), then an open partial
      // matrix at the last row: the tie keeps the first pair and the partial
      // row is dropped.
      for (int m = 0; m < 3; m++) begin
         push_row(16'sh7FFF, (m == 1) ? 16'sd1 : -16'sd1, 16'sd256, 1'b0, PH_STEADY);
         push_row(-16'sd256, 16'sd1, 16'sd0, 1'b0, PH_STEADY);
         push_row(16'sd0, 16'sd0, (m == 2) ? 16'sh7FFF : -16'sh7FFF, 1'b0, PH_STEADY);
      end
      push_row(16'sh7FFF, 16'sh8000, 16'sd5, 1'b1, PH_STEADY);
      hold_at = rows_pending.size();

      // Burst of small sets that runs while the receiver is held off.
      for (int s = 0; s < 8; s++) begin
         void'(queue_set(2, 0, PH_STEADY));
      end

      // Random part: mostly small sets, a few medium ones, and a full store
      // and an over-full store forced early on so they are always covered.
      queued = 0;
      set_no = 0;
      while (queued < RANDOM_ROWS) begin
         ph = traffic_phase_t'(queued * 4 / RANDOM_ROWS);
         pick = $urandom_range(99);
         if (set_no == 3) begin
            matrices = MAX_MATRICES;
         end else if (set_no == 12) begin
            matrices = MAX_MATRICES + 3;
         end else if (pick < 70) begin
            matrices = $urandom_range(6);
         end else if (pick < 95) begin
            matrices = $urandom_range(20, 7);
         end else if (pick < 98) begin
            matrices = $urandom_range(MAX_MATRICES - 1, 21);
         end else begin
            matrices = $urandom_range(MAX_MATRICES + 6, MAX_MATRICES);
         end
         partial = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
         queued += queue_set(matrices, partial, ph);
         set_no++;
      end

      // Reset once, then let the driver and monitor run.
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Polled at the rising edge, where the driver's queue and counters are
      // both settled.
      while (rows_pending.size() != 0 || rows_offered != rows_accepted ||
             closest_expected.size() != 0) begin
         @(posedge clock);
      end
      // Any result arriving now has no expectation and is flagged.
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("tb: %0d rows over %0d cycles, %0d results",
               rows_accepted, cycle_count, results_seen);
      $display("tb: %0d with too few matrices, %0d over capacity, largest set %0d matrices,",
               few_results, over_results, largest_set);
      $display("tb: input held %0d cycles during the receiver hold-off", held_stalls);
      if (mismatches == 0 && closest_expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mncp_pkg.sv
hw/rtl/mncp_ram.sv
hw/rtl/mncp_isqrt.sv
hw/rtl/matrix_norm_closest_pair_top.sv
hw/rtl/mncp_checker.sv
tb/sv/tb_matrix_norm_closest_pair_top.sv
